@@ hdl/u8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package u8sd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned PendW = 2;

    localparam logic [1:0] ContTag  = 2'b10;
    localparam logic [2:0] Lead2Tag = 3'b110;
    localparam logic [3:0] Lead3Tag = 4'b1110;
    localparam logic [4:0] Lead4Tag = 5'b11110;

    localparam logic [PendW-1:0] Pend0 = 2'd0;
    localparam logic [PendW-1:0] Pend1 = 2'd1;
    localparam logic [PendW-1:0] Pend2 = 2'd2;
    localparam logic [PendW-1:0] Pend3 = 2'd3;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           decode_error;
        logic           final_result;
    } t_result;

endpackage

@@ hdl/utf8_stream_decoder_unit.sv @@
// UTF-8 stream decoder: one byte per transfer in, one code point or error out.
// A byte waits in the input register until the result register is free; it is then
// decoded and any result is loaded there. Throughput: one byte per cycle while the
// result register is free, set by the combinational decode step between the two.
// Reset: synchronous active-low i_rst_n clears the decode state and both valid flags.
// Depends on u8sd_pkg, u8sd_step and u8sd_out_reg.
module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // decode_error
    output logic        m_axis_tlast    // final_result
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_end;
    logic             out_free;
    logic             advance;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    u8sd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    u8sd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{(24-CpW){1'b0}}, out_res.code_point};
    assign m_axis_tuser = out_res.decode_error;
    assign m_axis_tlast = out_res.final_result;

endmodule

@@ hdl/u8sd_step.sv @@
// Decoder state and per-byte next-state logic.
// Depends on u8sd_pkg.
module u8sd_step
    import u8sd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_end,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [PendW-1:0] r_pend, n_pend;
    logic [CpW-1:0]   r_part, n_part;
    logic             r_disc, n_disc;
    logic             is_err;
    logic [CpW-1:0]   acc;
    logic [PendW-1:0] pend_dec;

    assign acc      = {r_part[CpW-7:0], i_byte[5:0]};
    assign pend_dec = r_pend - Pend1;

    always_comb begin
        n_pend      = r_pend;
        n_part      = r_part;
        n_disc      = r_disc;
        is_err      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_disc) begin
            if (i_end) begin
                n_disc = 1'b0;
                n_pend = Pend0;
                n_part = '0;
            end
        end else if (r_pend == Pend0) begin
            if (!i_byte[7]) begin
                o_res_valid       = 1'b1;
                o_res.code_point  = {{(CpW-ByteW){1'b0}}, i_byte};
                o_res.final_result = i_end;
            end else if (i_byte[7:6] == ContTag) begin
                is_err = 1'b1;
            end else if (i_byte[7:5] == Lead2Tag) begin
                n_part = {{(CpW-5){1'b0}}, i_byte[4:0]};
                n_pend = Pend1;
                is_err = i_end;
            end else if (i_byte[7:4] == Lead3Tag) begin
                n_part = {{(CpW-4){1'b0}}, i_byte[3:0]};
                n_pend = Pend2;
                is_err = i_end;
            end else if (i_byte[7:3] == Lead4Tag) begin
                n_part = {{(CpW-3){1'b0}}, i_byte[2:0]};
                n_pend = Pend3;
                is_err = i_end;
            end else begin
                is_err = 1'b1;
            end
        end else if (i_byte[7:6] != ContTag) begin
            is_err = 1'b1;
        end else if (pend_dec == Pend0) begin
            n_pend             = Pend0;
            n_part             = '0;
            o_res_valid        = 1'b1;
            o_res.code_point   = acc;
            o_res.final_result = i_end;
        end else begin
            n_pend = pend_dec;
            n_part = acc;
            is_err = i_end;
        end

        if (is_err) begin
            n_pend       = Pend0;
            n_part       = '0;
            n_disc       = !i_end;
            o_res_valid  = 1'b1;
            o_res        = '0;
            o_res.decode_error = 1'b1;
            o_res.final_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= Pend0;
            r_part <= '0;
            r_disc <= 1'b0;
        end else if (i_fire) begin
            r_pend <= n_pend;
            r_part <= n_part;
            r_disc <= n_disc;
        end
    end

endmodule

@@ hdl/u8sd_out_reg.sv @@
// Result register on the master side of the decoder.
// Depends on u8sd_pkg.
module u8sd_out_reg
    import u8sd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder_unit: directed byte table, then random strings.
// Checks outputs against a UTF-8 predictor or typed rows' results; needs u8sd_pkg.
module tb_top;
    import u8sd_pkg::*;

    localparam int unsigned DirectedRows = 24;
    localparam int unsigned RandomBytes  = 1100;
    localparam int unsigned PauseAt      = 600;
    localparam int unsigned HoldAt       = 400;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned DrainCycles  = 10;
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned ReportMax    = 10;

    localparam t_result DecodeFail = '{'0, 1'b1, 1'b1};

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
        logic             typed;
        t_result          want;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // string_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [20:0] code_point, [23:21] zero
    logic        m_axis_tuser;   // decode_error
    logic        m_axis_tlast;   // final_result

    t_stim       in_flight = '0;
    t_stim       stim_q[$];
    t_result     expected_decodes[$];
    int unsigned n_fail = 0;
    int unsigned n_accepted = 0;

    logic [PendW-1:0] dec_pend = Pend0;
    logic [CpW-1:0]   dec_acc = '0;
    logic             dec_skip = 1'b0;

    assign s_axis_tdata = in_flight.data;
    assign s_axis_tlast = in_flight.last;

    utf8_stream_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit abort_string(input logic last, output t_result r);
        dec_pend = Pend0;
        dec_acc  = '0;
        dec_skip = !last;
        r = DecodeFail;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic last,
                                       output t_result r);
        r = '0;
        if (dec_skip) begin
            if (last) begin
                dec_skip = 1'b0;
                dec_pend = Pend0;
                dec_acc  = '0;
            end
            return 1'b0;
        end
        if (dec_pend == Pend0) begin
            if (!b[7]) begin
                r.code_point   = CpW'(b);
                r.final_result = last;
                return 1'b1;
            end
            if (b[7:5] == Lead2Tag) begin
                dec_acc  = CpW'(b[4:0]);
                dec_pend = Pend1;
            end else if (b[7:4] == Lead3Tag) begin
                dec_acc  = CpW'(b[3:0]);
                dec_pend = Pend2;
            end else if (b[7:3] == Lead4Tag) begin
                dec_acc  = CpW'(b[2:0]);
                dec_pend = Pend3;
            end else begin
                return abort_string(last, r);
            end
            if (last) return abort_string(last, r);
            return 1'b0;
        end
        if (b[7:6] != ContTag) return abort_string(last, r);
        dec_acc  = {dec_acc[CpW-7:0], b[5:0]};
        dec_pend = dec_pend - 1'b1;
        if (dec_pend == Pend0) begin
            r.code_point   = dec_acc;
            r.final_result = last;
            dec_acc = '0;
            return 1'b1;
        end
        if (last) return abort_string(last, r);
        return 1'b0;
    endfunction

    function automatic void report_mismatch(input string what, input t_result want,
                                            input t_result got);
        n_fail++;
        if (n_fail <= ReportMax) begin
            $display("%0t: %s: expected cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
                     $realtime, what, want.code_point, want.decode_error, want.final_result,
                     got.code_point, got.decode_error, got.final_result);
        end
    endfunction

    task automatic add_row(input logic [ByteW-1:0] d, input logic l, input bit typed = 1'b0,
                           input t_result w = '0);
        t_stim row;
        row.data  = d;
        row.last  = l;
        row.typed = typed;
        row.want  = w;
        stim_q.insert(stim_q.size(), row);
    endtask

    task automatic add_random_string();
        logic [ByteW-1:0] bytes[$];
        int unsigned shape;
        int unsigned n_cont;
        int unsigned cut;
        shape = $urandom_range(0, 99);
        if (shape >= 92) begin
            repeat ($urandom_range(1, 8)) bytes.insert(bytes.size(), 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                n_cont = 0;
                case ($urandom_range(0, 3))
                    0: bytes.insert(bytes.size(), {1'b0, 7'($urandom)});
                    1: begin
                        bytes.insert(bytes.size(), {Lead2Tag, 5'($urandom)});
                        n_cont = 1;
                    end
                    2: begin
                        bytes.insert(bytes.size(), {Lead3Tag, 4'($urandom)});
                        n_cont = 2;
                    end
                    default: begin
                        bytes.insert(bytes.size(), {Lead4Tag, 3'($urandom)});
                        n_cont = 3;
                    end
                endcase
                repeat (n_cont) bytes.insert(bytes.size(), {ContTag, 6'($urandom)});
            end
            if (shape >= 75 && shape < 85) begin
                bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom);
            end else if (shape >= 85) begin
                cut = $urandom_range(1, bytes.size());
                while (bytes.size() > cut) bytes.pop_back();
            end
        end
        foreach (bytes[i]) add_row(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic drive_item(input t_stim it, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        in_flight     <= it;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[CpW-1:0], m_axis_tuser, m_axis_tlast};
                if (expected_decodes.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, got);
                end else begin
                    want = expected_decodes.pop_front();
                    if (got.code_point != want.code_point || m_axis_tdata[23:CpW] != '0 ||
                        got.decode_error != want.decode_error ||
                        got.final_result != want.final_result) begin
                        report_mismatch("field mismatch", want, got);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_accepted++;
                if (decode_byte(in_flight.data, in_flight.last, pred)) begin
                    expected_decodes.insert(expected_decodes.size(),
                                            in_flight.typed ? in_flight.want : pred);
                end
            end
        end
    end

    initial begin : sink
        int unsigned stall;
        bit held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_accepted >= HoldAt) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            stall = pick_gap();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge i_clk);
            else repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned n_sent;
        int unsigned burst;
        t_stim it;
        add_row(8'h00, 1'b1, 1'b1, '{21'h000000, 1'b0, 1'b1});
        add_row(8'h7F, 1'b0, 1'b1, '{21'h00007F, 1'b0, 1'b0});
        add_row(8'hC2, 1'b0);
        add_row(8'hA9, 1'b0);
        add_row(8'hE2, 1'b0);
        add_row(8'h82, 1'b0);
        add_row(8'hAC, 1'b1);
        add_row(8'hF7, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, 1'b0, 1'b0});
        add_row(8'h80, 1'b0, 1'b1, DecodeFail);
        add_row(8'h41, 1'b1);
        add_row(8'hFF, 1'b1, 1'b1, DecodeFail);
        add_row(8'hF8, 1'b0, 1'b1, DecodeFail);
        add_row(8'h00, 1'b1);
        add_row(8'hC3, 1'b0);
        add_row(8'h41, 1'b0, 1'b1, DecodeFail);
        add_row(8'hC0, 1'b1);
        add_row(8'hE0, 1'b1, 1'b1, DecodeFail);
        add_row(8'hE1, 1'b0);
        add_row(8'h80, 1'b1, 1'b1, DecodeFail);
        add_row(8'hC0, 1'b0);
        add_row(8'h80, 1'b1, 1'b1, '{21'h000000, 1'b0, 1'b1});
        while (stim_q.size() < DirectedRows + RandomBytes) add_random_string();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_sent = 0;
        burst  = 0;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            if (n_sent == DirectedRows || n_sent == PauseAt) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (expected_decodes.size() != 0) @(posedge i_clk);
            end
            if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
            drive_item(it, burst != 0);
            if (burst != 0) burst--;
            n_sent++;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (n_fail == 0 && expected_decodes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/u8sd_pkg.sv
hdl/u8sd_step.sv
hdl/u8sd_out_reg.sv
hdl/utf8_stream_decoder_unit.sv
sim/tb_top.sv
